// ===== sv/ckb_pkg.sv =====
// ckb_pkg: shared constants for the color-keyed tile pixel blitter.
// No dependencies; used by the channel interfaces and the top level.
package ckb_pkg;

    // Input transaction field widths
    localparam int TILE_W   = 8;
    localparam int ORIGIN_W = 11;
    localparam int OFFSET_W = 4;
    localparam int INDEX_W  = 8;
    localparam int COLOR_W  = 32;

    // Output transaction field widths
    localparam int ADDR_W = 16;

    // Palette store
    localparam int PALETTE_DEPTH = 256;

    // Transaction function codes
    localparam logic FUNC_DRAW  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int TCOUNT_W   = 9;

    localparam logic [1:0] REG_TRANSPARENT = 2'd0;
    localparam logic [1:0] REG_TINT        = 2'd1;
    localparam logic [1:0] REG_TILE_COUNT  = 2'd2;

    localparam logic [INDEX_W-1:0]  TRANSPARENT_RESET = 8'h00;
    localparam logic [COLOR_W-1:0]  TINT_RESET        = 32'hFF80_8080;
    localparam logic [TCOUNT_W-1:0] TILE_COUNT_RESET  = 9'd256;

    // Blending
    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam int CHAN_W = 8;

endpackage

// ===== sv/ckb_if.sv =====
// ckb_if: valid/ready channel interfaces for pixel input and framebuffer output.
// Depends on ckb_pkg for field widths.
interface ckb_pix_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic [ckb_pkg::TILE_W-1:0]             tile_index;
    logic signed [ckb_pkg::ORIGIN_W-1:0]    origin_x;
    logic signed [ckb_pkg::ORIGIN_W-1:0]    origin_y;
    logic [ckb_pkg::OFFSET_W-1:0]           offset_x;
    logic [ckb_pkg::OFFSET_W-1:0]           offset_y;
    logic [ckb_pkg::INDEX_W-1:0]            pixel_index;
    logic                                   tint_enable;
    logic [ckb_pkg::COLOR_W-1:0]            palette_color;

    modport source (
        output valid, func, tile_index, origin_x, origin_y, offset_x, offset_y,
               pixel_index, tint_enable, palette_color,
        input  ready
    );
    modport sink (
        input  valid, func, tile_index, origin_x, origin_y, offset_x, offset_y,
               pixel_index, tint_enable, palette_color,
        output ready
    );
endinterface

interface ckb_fb_if;
    logic                           valid;
    logic                           ready;
    logic [ckb_pkg::ADDR_W-1:0]     frame_address;
    logic [ckb_pkg::COLOR_W-1:0]    pixel_color;

    modport source (
        output valid, frame_address, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, frame_address, pixel_color,
        output ready
    );
endinterface

// ===== sv/ckb_ram.sv =====
// ckb_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module ckb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read returns the contents before a same-edge write
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/color_keyed_tile_pixel_blitter_unit.sv =====
// color_keyed_tile_pixel_blitter_unit: top level of the palettized tile pixel blitter.
// Depends on ckb_pkg, ckb_pix_if / ckb_fb_if and ckb_ram.
//
// The block takes transactions on pix_in and, for each drawn pixel, produces one
// transaction on fb_out via the stage 1 and output registers. A palette-write
// transaction (func = 1) stores palette_color at pixel_index and yields nothing.
// A draw transaction yields nothing when the tile index is not below tile_count,
// when pixel_index equals the transparent key, when an offset is not below
// TILE_SIZE, or when the pixel is off screen; otherwise it yields the linear
// address row * SCREEN_WIDTH + column (low 16 bits) and the palette color,
// optionally averaged 50/50 per channel with tint_color and made opaque.
// Sustained rate is one transaction per clock while fb_out is ready: the single
// palette RAM read port serves one draw per cycle, and a write lands before any
// later read. Palette entries hold garbage until written; there is no clearing
// pass. Registers (APB, 32-bit) are to be written when the block is idle, which
// it does not enforce: 0x0 transparent_index, 0x4 tint_color, 0x8 tile_count.
module color_keyed_tile_pixel_blitter_unit #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int TILE_SIZE     = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ckb_pix_if.sink                         pix_in,
    ckb_fb_if.source                        fb_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ckb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ckb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ckb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    // Coordinate widths: an on-screen column / row fits these
    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int PROD_W = XW + YW + 1;
    localparam int SUM_W = (PROD_W > ckb_pkg::ADDR_W) ? PROD_W : ckb_pkg::ADDR_W;
    localparam int IDX_W = $clog2(ckb_pkg::PALETTE_DEPTH);
    localparam int CW    = ckb_pkg::ORIGIN_W + 1;   // origin plus offset

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ckb_pkg::INDEX_W-1:0]  transparent_reg;
    logic [ckb_pkg::COLOR_W-1:0]  tint_reg;
    logic [ckb_pkg::TCOUNT_W-1:0] tile_count_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transparent_reg <= ckb_pkg::TRANSPARENT_RESET;
            tint_reg        <= ckb_pkg::TINT_RESET;
            tile_count_reg  <= ckb_pkg::TILE_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                ckb_pkg::REG_TRANSPARENT: transparent_reg <= pwdata[ckb_pkg::INDEX_W-1:0];
                ckb_pkg::REG_TINT:        tint_reg        <= pwdata[ckb_pkg::COLOR_W-1:0];
                ckb_pkg::REG_TILE_COUNT:  tile_count_reg  <= pwdata[ckb_pkg::TCOUNT_W-1:0];
                default:                  ; // unmapped, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ckb_pkg::REG_TRANSPARENT:
                prdata = {{(ckb_pkg::APB_DATA_W-ckb_pkg::INDEX_W){1'b0}}, transparent_reg};
            ckb_pkg::REG_TINT:
                prdata = tint_reg;
            ckb_pkg::REG_TILE_COUNT:
                prdata = {{(ckb_pkg::APB_DATA_W-ckb_pkg::TCOUNT_W){1'b0}}, tile_count_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake and pipeline control
    // ---------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_adv, accept;

    // Output register drains or is empty -> stage 1 can move on
    assign s1_adv       = !out_valid_reg || fb_out.ready;
    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign accept       = pix_in.valid && pix_in.ready;

    // ---------------------------------------------------------------
    // Stage 0: drop checks, screen position, palette access
    // ---------------------------------------------------------------
    logic [CW-1:0] dx, dy;
    logic          tile_ok, key_ok, offs_ok, x_ok, y_ok, draw_ok;
    logic          is_draw;

    assign is_draw = (pix_in.func == ckb_pkg::FUNC_DRAW);

    // sign-extend origin, add unsigned offset; bit CW-1 is the sign
    assign dx = {pix_in.origin_x[ckb_pkg::ORIGIN_W-1], pix_in.origin_x}
              + CW'(pix_in.offset_x);
    assign dy = {pix_in.origin_y[ckb_pkg::ORIGIN_W-1], pix_in.origin_y}
              + CW'(pix_in.offset_y);

    assign tile_ok = {1'b0, pix_in.tile_index} < tile_count_reg;
    assign key_ok  = pix_in.pixel_index != transparent_reg;
    assign offs_ok = (7'(pix_in.offset_x) < 7'(TILE_SIZE))
                  && (7'(pix_in.offset_y) < 7'(TILE_SIZE));
    assign x_ok    = !dx[CW-1] && (dx[CW-2:0] < (CW-1)'(SCREEN_WIDTH));
    assign y_ok    = !dy[CW-1] && (dy[CW-2:0] < (CW-1)'(SCREEN_HEIGHT));
    assign draw_ok = is_draw && tile_ok && key_ok && offs_ok && x_ok && y_ok;

    // Palette RAM. Read is only enabled on a draw, so read data holds while
    // stage 1 is stalled. A write always lands before any later read.
    logic [ckb_pkg::COLOR_W-1:0] pal_rdata;

    ckb_ram #(
        .WIDTH (ckb_pkg::COLOR_W),
        .DEPTH (ckb_pkg::PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (accept && !is_draw),
        .waddr (pix_in.pixel_index[IDX_W-1:0]),
        .wdata (pix_in.palette_color),
        .re    (accept && draw_ok),
        .raddr (pix_in.pixel_index[IDX_W-1:0]),
        .rdata (pal_rdata)
    );

    // Stage 1 payload
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    logic          s1_tint_reg;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = draw_ok;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= dx[XW-1:0];
            s1_y_reg    <= dy[YW-1:0];
            s1_tint_reg <= pix_in.tint_enable;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: address multiply-add and tint blend into output register
    // ---------------------------------------------------------------
    logic [SUM_W-1:0]            addr_full;
    logic [ckb_pkg::COLOR_W-1:0] blend, color;

    assign addr_full = SUM_W'(s1_y_reg) * SUM_W'(SCREEN_WIDTH) + SUM_W'(s1_x_reg);

    // per-channel floor((a + b) / 2) on RGB, alpha forced opaque
    always_comb
    begin
        blend = ckb_pkg::ALPHA_OPAQUE;
        for (int ch = 0; ch < 3; ch++)
        begin
            blend[ch*ckb_pkg::CHAN_W +: ckb_pkg::CHAN_W] = ckb_pkg::CHAN_W'(
                ({1'b0, pal_rdata[ch*ckb_pkg::CHAN_W +: ckb_pkg::CHAN_W]}
               + {1'b0, tint_reg[ch*ckb_pkg::CHAN_W +: ckb_pkg::CHAN_W]}) >> 1);
        end
    end

    assign color = s1_tint_reg ? blend : pal_rdata;

    logic [ckb_pkg::ADDR_W-1:0]  frame_address_reg;
    logic [ckb_pkg::COLOR_W-1:0] pixel_color_reg;

    assign out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            frame_address_reg <= addr_full[ckb_pkg::ADDR_W-1:0];
            pixel_color_reg   <= color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign fb_out.valid         = out_valid_reg;
    assign fb_out.frame_address = frame_address_reg;
    assign fb_out.pixel_color   = pixel_color_reg;

endmodule
